### rtl/core/iggfr_pkg.sv
package iggfr_pkg;

    // Only the header and the gain words are ever read back out of a frame.
    localparam int HELD_BYTES = 16;

    localparam logic [7:0] HDR_BYTE0 = 8'h8a;
    localparam logic [7:0] HDR_BYTE1 = 8'h8b;
    localparam logic [7:0] HDR_BYTE2 = 8'h1c;
    localparam logic [7:0] HDR_BYTE3 = 8'hae;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam logic REG_IDLE_LIMIT   = 1'b0;
    localparam logic REG_PARSE_ENABLE = 1'b1;

    localparam logic [15:0] IDLE_LIMIT_RST   = 16'd10;
    localparam logic        PARSE_ENABLE_RST = 1'b1;

    typedef struct packed {
        logic [15:0] idle_limit;
        logic        parse_enable;
    } cfg_t;

    typedef struct packed {
        logic        gains_valid;
        logic [15:0] inner_p_gain;
        logic [15:0] inner_i_gain;
        logic [15:0] inner_d_gain;
        logic [15:0] outer_p_gain;
        logic [15:0] outer_i_gain;
        logic [15:0] outer_d_gain;
        logic [5:0]  frame_length;
    } result_t;

endpackage

### rtl/core/idle_gap_gain_frame_receiver_top.sv
// Frame receiver: byte transfers (mode 0) fill the frame buffer, tick transfers
// (mode 1) run the idle-gap poll, and the tick that reaches idle_limit idle ticks
// emits one result and restarts the frame. One item is taken every cycle while in_stall
// is low; a result is presented once its tick has passed through an input register and
// a result register. The input stalls only when a frame-ending tick waits on a held,
// stalled result. Registers: idle_limit at 0x0, parse_enable at 0x4.
module idle_gap_gain_frame_receiver_top #(
    parameter int BUFFER_BYTES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        gains_valid,
    output logic [15:0] inner_p_gain,
    output logic [15:0] inner_i_gain,
    output logic [15:0] inner_d_gain,
    output logic [15:0] outer_p_gain,
    output logic [15:0] outer_i_gain,
    output logic [15:0] outer_d_gain,
    output logic [5:0]  frame_length,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    iggfr_pkg::cfg_t    cfg;
    iggfr_pkg::result_t result;
    iggfr_pkg::result_t res_reg;

    logic       s1_valid_reg;
    logic       s1_mode_reg;
    logic [7:0] s1_byte_reg;
    logic       out_valid_reg;
    logic       frame_end;
    logic       out_free;
    logic       step;
    logic       in_take;

    iggfr_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    iggfr_frame_ctrl #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item_mode (s1_mode_reg),
        .item_byte (s1_byte_reg),
        .cfg       (cfg),
        .frame_end (frame_end),
        .result    (result)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign step     = s1_valid_reg && (!frame_end || out_free);
    assign in_stall = s1_valid_reg && !step;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (step)
                s1_valid_reg <= 1'b0;

            if (step && frame_end)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_mode_reg <= mode;
            s1_byte_reg <= rx_byte;
        end
        if (step && frame_end)
            res_reg <= result;
    end

    assign out_valid    = out_valid_reg;
    assign gains_valid  = res_reg.gains_valid;
    assign inner_p_gain = res_reg.inner_p_gain;
    assign inner_i_gain = res_reg.inner_i_gain;
    assign inner_d_gain = res_reg.inner_d_gain;
    assign outer_p_gain = res_reg.outer_p_gain;
    assign outer_i_gain = res_reg.outer_i_gain;
    assign outer_d_gain = res_reg.outer_d_gain;
    assign frame_length = res_reg.frame_length;

`ifndef SYNTHESIS
    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a blocked result");

    a_frame_end_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        (step && frame_end) |=> out_valid_reg)
        else $error("frame end did not produce a result");

    a_gains_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !gains_valid) |->
        (inner_p_gain == 16'd0 && inner_i_gain == 16'd0 && inner_d_gain == 16'd0 &&
         outer_p_gain == 16'd0 && outer_i_gain == 16'd0 && outer_d_gain == 16'd0))
        else $error("gains not cleared on an unparsed frame");
`endif

endmodule

### rtl/core/iggfr_apb_regs.sv
module iggfr_apb_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output iggfr_pkg::cfg_t     cfg
);

    logic [15:0] idle_limit_reg;
    logic        parse_enable_reg;
    logic        wr_en;
    logic        reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_limit_reg   <= iggfr_pkg::IDLE_LIMIT_RST;
            parse_enable_reg <= iggfr_pkg::PARSE_ENABLE_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                iggfr_pkg::REG_IDLE_LIMIT:   idle_limit_reg   <= pwdata[15:0];
                iggfr_pkg::REG_PARSE_ENABLE: parse_enable_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            iggfr_pkg::REG_IDLE_LIMIT:   prdata = {16'd0, idle_limit_reg};
            iggfr_pkg::REG_PARSE_ENABLE: prdata = {31'd0, parse_enable_reg};
            default:                     prdata = '0;
        endcase
    end

    assign cfg.idle_limit   = idle_limit_reg;
    assign cfg.parse_enable = parse_enable_reg;

endmodule

### rtl/core/iggfr_frame_ctrl.sv
module iggfr_frame_ctrl #(
    parameter int BUFFER_BYTES = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 item_mode,
    input  logic [7:0]           item_byte,
    input  iggfr_pkg::cfg_t      cfg,
    output logic                 frame_end,
    output iggfr_pkg::result_t   result
);

    localparam int CntW  = $clog2(BUFFER_BYTES + 1);
    localparam int HeldN = iggfr_pkg::HELD_BYTES;

    logic [7:0]      held_reg [HeldN];
    logic [7:0]      rd       [HeldN];
    logic [CntW-1:0] count_reg, count_next;
    logic [CntW-1:0] last_reg, last_next;
    logic [15:0]     idle_reg, idle_next, idle_inc;
    logic            receiving_reg, receiving_next;
    logic [CntW+5:0] count_wide;
    logic            hdr_ok;
    logic            gains_ok;

    // Store the first bytes of a frame; later positions are never read.
    always_ff @(posedge clk)
    begin
        for (int p = 0; p < HeldN; p++)
        begin
            if (step && item_mode == iggfr_pkg::MODE_BYTE && count_reg == CntW'(p))
                held_reg[p] <= item_byte;
        end
    end

    // Positions at or beyond the byte count are masked to read zero.
    always_comb
    begin
        for (int p = 0; p < HeldN; p++)
            rd[p] = (CntW'(p) < count_reg) ? held_reg[p] : 8'd0;
    end

    assign idle_inc = (idle_reg == 16'hffff) ? idle_reg : idle_reg + 16'd1;

    always_comb
    begin
        count_next     = count_reg;
        last_next      = last_reg;
        idle_next      = idle_reg;
        receiving_next = receiving_reg;
        frame_end      = 1'b0;
        if (item_mode == iggfr_pkg::MODE_BYTE)
        begin
            if (count_reg < CntW'(BUFFER_BYTES))
                count_next = count_reg + 1'b1;
        end
        else
        begin
            if (!receiving_reg)
            begin
                if (count_reg != '0)
                begin
                    receiving_next = 1'b1;
                    last_next      = count_reg;
                end
            end
            else if (count_reg == last_reg)
            begin
                idle_next = idle_inc;
                frame_end = (idle_inc >= cfg.idle_limit);
            end
            else
            begin
                idle_next = 16'd0;
                last_next = count_reg;
            end
            if (frame_end)
            begin
                count_next     = '0;
                last_next      = '0;
                idle_next      = 16'd0;
                receiving_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            last_reg      <= '0;
            idle_reg      <= 16'd0;
            receiving_reg <= 1'b0;
        end
        else if (step)
        begin
            count_reg     <= count_next;
            last_reg      <= last_next;
            idle_reg      <= idle_next;
            receiving_reg <= receiving_next;
        end
    end

    assign hdr_ok = (rd[0] == iggfr_pkg::HDR_BYTE0) && (rd[1] == iggfr_pkg::HDR_BYTE1) &&
                    (rd[2] == iggfr_pkg::HDR_BYTE2) && (rd[3] == iggfr_pkg::HDR_BYTE3);
    assign gains_ok   = cfg.parse_enable && hdr_ok;
    assign count_wide = (CntW + 6)'(count_reg);

    assign result.gains_valid  = gains_ok;
    assign result.inner_p_gain = gains_ok ? {rd[4],  rd[5]}  : 16'd0;
    assign result.inner_i_gain = gains_ok ? {rd[6],  rd[7]}  : 16'd0;
    assign result.inner_d_gain = gains_ok ? {rd[8],  rd[9]}  : 16'd0;
    assign result.outer_p_gain = gains_ok ? {rd[10], rd[11]} : 16'd0;
    assign result.outer_i_gain = gains_ok ? {rd[12], rd[13]} : 16'd0;
    assign result.outer_d_gain = gains_ok ? {rd[14], rd[15]} : 16'd0;
    assign result.frame_length = count_wide[5:0];

endmodule

### bench/idle_gap_gain_frame_receiver_check.sv
`timescale 1ns / 100ps

module idle_gap_gain_frame_receiver_check #(
    parameter int BUFFER_BYTES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        mode,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        gains_valid,
    input  logic [15:0] inner_p_gain,
    input  logic [15:0] inner_i_gain,
    input  logic [15:0] inner_d_gain,
    input  logic [15:0] outer_p_gain,
    input  logic [15:0] outer_i_gain,
    input  logic [15:0] outer_d_gain,
    input  logic [5:0]  frame_length,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          frames_pending,
    output int          frames_seen,
    output int          gain_frames_seen
);

    typedef enum logic [1:0] {
        RX_IDLE,
        RX_RECEIVING,
        RX_ENDED
    } rx_phase_t;

    logic [7:0]         frame_buf [BUFFER_BYTES];
    int unsigned        held;
    int unsigned        held_at_poll;
    logic [15:0]        gap_ticks;
    rx_phase_t          phase;
    logic [15:0]        cfg_idle_limit;
    logic               cfg_parse;
    iggfr_pkg::result_t expected_frames [$];

    function automatic void clear_frame();
        foreach (frame_buf[i]) frame_buf[i] = '0;
        held = 0;
        held_at_poll = 0;
        gap_ticks = '0;
        phase = RX_IDLE;
    endfunction

    // Predict the effect of one accepted transfer; a frame-ending tick queues a result.
    function automatic void absorb_item(input logic m, input logic [7:0] b);
        iggfr_pkg::result_t r;
        logic               hit;
        if (m == iggfr_pkg::MODE_BYTE)
        begin
            if (held < BUFFER_BYTES)
            begin
                frame_buf[held] = b;
                held++;
            end
            return;
        end
        case (phase)
            RX_IDLE:
                if (held > 0)
                begin
                    phase = RX_RECEIVING;
                    held_at_poll = held;
                end
            RX_RECEIVING:
                if (held == held_at_poll)
                begin
                    if (gap_ticks != 16'hffff) gap_ticks++;
                    if (gap_ticks >= cfg_idle_limit) phase = RX_ENDED;
                end
                else if (held > held_at_poll)
                begin
                    gap_ticks = '0;
                    held_at_poll = held;
                end
            default: ;
        endcase
        if (phase != RX_ENDED) return;
        hit = cfg_parse &&
              frame_buf[0] == iggfr_pkg::HDR_BYTE0 && frame_buf[1] == iggfr_pkg::HDR_BYTE1 &&
              frame_buf[2] == iggfr_pkg::HDR_BYTE2 && frame_buf[3] == iggfr_pkg::HDR_BYTE3;
        r.gains_valid  = hit;
        r.inner_p_gain = hit ? {frame_buf[4], frame_buf[5]} : 16'h0;
        r.inner_i_gain = hit ? {frame_buf[6], frame_buf[7]} : 16'h0;
        r.inner_d_gain = hit ? {frame_buf[8], frame_buf[9]} : 16'h0;
        r.outer_p_gain = hit ? {frame_buf[10], frame_buf[11]} : 16'h0;
        r.outer_i_gain = hit ? {frame_buf[12], frame_buf[13]} : 16'h0;
        r.outer_d_gain = hit ? {frame_buf[14], frame_buf[15]} : 16'h0;
        r.frame_length = held[5:0];
        expected_frames.push_back(r);
        clear_frame();
    endfunction

    function automatic void compare_field(input string field, input logic [15:0] got,
                                          input logic [15:0] want);
        if (got !== want)
        begin
            if (fail_count < 10)
                $display("frame %0d %s: expected %0h, got %0h", frames_seen, field, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_frame();
        iggfr_pkg::result_t want;
        if (expected_frames.size() == 0)
        begin
            if (fail_count < 10)
                $display("result transfer with no frame end predicted, length %0d",
                         frame_length);
            fail_count++;
            return;
        end
        want = expected_frames.pop_front();
        compare_field("gains_valid", 16'(gains_valid), 16'(want.gains_valid));
        compare_field("inner_p_gain", inner_p_gain, want.inner_p_gain);
        compare_field("inner_i_gain", inner_i_gain, want.inner_i_gain);
        compare_field("inner_d_gain", inner_d_gain, want.inner_d_gain);
        compare_field("outer_p_gain", outer_p_gain, want.outer_p_gain);
        compare_field("outer_i_gain", outer_i_gain, want.outer_i_gain);
        compare_field("outer_d_gain", outer_d_gain, want.outer_d_gain);
        compare_field("frame_length", 16'(frame_length), 16'(want.frame_length));
        frames_seen++;
        if (want.gains_valid) gain_frames_seen++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_frame();
            cfg_idle_limit = iggfr_pkg::IDLE_LIMIT_RST;
            cfg_parse = iggfr_pkg::PARSE_ENABLE_RST;
            expected_frames.delete();
            fail_count = 0;
            frames_pending = 0;
            frames_seen = 0;
            gain_frames_seen = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == {iggfr_pkg::REG_IDLE_LIMIT, 2'b00})
                    cfg_idle_limit = pwdata[15:0];
                else if (paddr == {iggfr_pkg::REG_PARSE_ENABLE, 2'b00})
                    cfg_parse = pwdata[0];
            end
            if (in_valid && !in_stall) absorb_item(mode, rx_byte);
            if (out_valid && !out_stall) check_frame();
            frames_pending = expected_frames.size();
        end
    end

endmodule

### bench/tb_idle_gap_gain_frame_receiver_top.sv
`timescale 1ns / 100ps

module tb_idle_gap_gain_frame_receiver_top;

    localparam int RUN_LIMIT   = 1_000_000;
    localparam int HOLD_CYCLES = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        mode = iggfr_pkg::MODE_BYTE;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_stall = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'b000;
    logic [31:0] pwdata = 32'h0;

    logic        in_stall;
    logic        out_valid;
    logic        gains_valid;
    logic [15:0] inner_p_gain;
    logic [15:0] inner_i_gain;
    logic [15:0] inner_d_gain;
    logic [15:0] outer_p_gain;
    logic [15:0] outer_i_gain;
    logic [15:0] outer_d_gain;
    logic [5:0]  frame_length;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int frames_pending;
    int frames_seen;
    int gain_frames_seen;

    int sent_items = 0;
    int cur_limit = int'(iggfr_pkg::IDLE_LIMIT_RST);
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count = 0;
    logic hold_req = 1'b0;
    logic hold_taken = 1'b0;
    int hold_left = 0;

    idle_gap_gain_frame_receiver_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .gains_valid  (gains_valid),
        .inner_p_gain (inner_p_gain),
        .inner_i_gain (inner_i_gain),
        .inner_d_gain (inner_d_gain),
        .outer_p_gain (outer_p_gain),
        .outer_i_gain (outer_i_gain),
        .outer_d_gain (outer_d_gain),
        .frame_length (frame_length),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    idle_gap_gain_frame_receiver_check gain_frame_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .mode             (mode),
        .rx_byte          (rx_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .gains_valid      (gains_valid),
        .inner_p_gain     (inner_p_gain),
        .inner_i_gain     (inner_i_gain),
        .inner_d_gain     (inner_d_gain),
        .outer_p_gain     (outer_p_gain),
        .outer_i_gain     (outer_i_gain),
        .outer_d_gain     (outer_d_gain),
        .frame_length     (frame_length),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .fail_count       (fail_count),
        .frames_pending   (frames_pending),
        .frames_seen      (frames_seen),
        .gain_frames_seen (gain_frames_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("tb_idle_gap_gain_frame_receiver_top NOT OK");
            $finish;
        end
    end

    // Result side: one long hold-off on request, random stalls otherwise.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_taken)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic logic [7:0] header_byte(input int pos);
        case (pos)
            0: return iggfr_pkg::HDR_BYTE0;
            1: return iggfr_pkg::HDR_BYTE1;
            2: return iggfr_pkg::HDR_BYTE2;
            default: return iggfr_pkg::HDR_BYTE3;
        endcase
    endfunction

    // Keep valid high across back-to-back transfers; drop it only for a gap.
    task automatic send_item(input logic m, input logic [7:0] b);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        mode <= m;
        rx_byte <= b;
        do @(posedge clk); while (in_stall);
        sent_items++;
    endtask

    // Negative fill gives random payload bytes; otherwise alternate fill and its inverse.
    task automatic send_frame(input int n_bytes, input bit good_hdr, input int fill,
                              input int end_ticks, input bit mid_polls);
        int bad_pos;
        logic [7:0] b;
        bad_pos = good_hdr ? -1 : int'($urandom_range(3));
        for (int i = 0; i < n_bytes; i++)
        begin
            if (i < 4)
                b = header_byte(i);
            else if (fill < 0)
                b = 8'($urandom);
            else
                b = i[0] ? ~fill[7:0] : fill[7:0];
            if (i == bad_pos)
                b ^= 8'(1 << $urandom_range(7));
            send_item(iggfr_pkg::MODE_BYTE, b);
            if (mid_polls && $urandom_range(99) < 15)
                send_item(iggfr_pkg::MODE_TICK, 8'($urandom));
        end
        repeat (end_ticks) send_item(iggfr_pkg::MODE_TICK, 8'($urandom));
    endtask

    // Hold until every predicted frame has arrived, then let the pipeline settle.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (frames_pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input int limit, input logic parse);
        drain();
        write_reg({iggfr_pkg::REG_IDLE_LIMIT, 2'b00}, 32'(limit));
        write_reg({iggfr_pkg::REG_PARSE_ENABLE, 2'b00}, {31'b0, parse});
        cur_limit = limit;
    endtask

    task automatic run_traffic(input int items);
        int stop_at;
        int pick;
        int n_bytes;
        int end_ticks;
        int eff;
        stop_at = sent_items + items;
        eff = (cur_limit == 0) ? 1 : cur_limit;
        while (sent_items < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                repeat ($urandom_range(5, 1))
                    send_item(1'($urandom_range(1)), 8'($urandom));
            end
            else
            begin
                pick = $urandom_range(99);
                n_bytes = (pick < 70) ? 16 :
                          (pick < 85) ? int'($urandom_range(15)) : int'($urandom_range(40, 17));
                // Now and then stop short of the gap so the next frame runs on.
                end_ticks = ($urandom_range(9) == 0) ? int'($urandom_range(eff)) :
                            eff + 1 + int'($urandom_range(2));
                send_frame(n_bytes, $urandom_range(4) != 0, -1, end_ticks, 1'b1);
            end
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: poll with nothing held, then a full gain frame.
        send_item(iggfr_pkg::MODE_TICK, 8'h00);
        send_frame(16, 1'b1, 8'hff, 11, 1'b0);

        set_config(1, 1'b1);
        send_frame(5, 1'b1, 8'h0f, 2, 1'b0);
        send_frame(40, 1'b1, 8'h00, 2, 1'b0);

        set_config(0, 1'b0);
        send_frame(16, 1'b1, 8'hff, 3, 1'b0);
        set_config(0, 1'b1);
        send_frame(16, 1'b0, -1, 2, 1'b0);

        // Lower the limit under a frame that has already sat idle past it.
        set_config(65535, 1'b1);
        send_frame(16, 1'b1, -1, 20, 1'b0);
        drain();
        write_reg({iggfr_pkg::REG_IDLE_LIMIT, 2'b00}, 32'd3);
        cur_limit = 3;
        send_item(iggfr_pkg::MODE_TICK, 8'hff);

        set_config(2, 1'b1);
        send_idle_pct = 35;
        recv_idle_pct <= 83;
        run_traffic(330);

        set_config(0, 1'b0);
        send_idle_pct = 83;
        recv_idle_pct <= 35;
        run_traffic(165);
        set_config(4, 1'b1);
        run_traffic(165);

        set_config(1, 1'b1);
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        hold_req <= 1'b1;
        repeat (6) send_frame(3, 1'b1, -1, 3, 1'b0);
        run_traffic(200);

        drain();
        $display("Drove %0d input transfers with idle limits from 0 to 65535,",
                 sent_items);
        $display("parsing on and off; checked %0d ended frames (%0d with valid gains).",
                 frames_seen, gain_frames_seen);
        if (fail_count == 0 && frames_pending == 0)
            $display("tb_idle_gap_gain_frame_receiver_top OK");
        else
            $display("tb_idle_gap_gain_frame_receiver_top NOT OK");
        $finish;
    end

endmodule

### idle_gap_gain_frame_receiver_top.f
rtl/core/iggfr_pkg.sv
rtl/core/iggfr_apb_regs.sv
rtl/core/iggfr_frame_ctrl.sv
rtl/core/idle_gap_gain_frame_receiver_top.sv
bench/idle_gap_gain_frame_receiver_check.sv
bench/tb_idle_gap_gain_frame_receiver_top.sv
